@@ hdl/olst_pkg.sv @@
`timescale 1ns / 1ps
package olst_pkg;

  // default sizing of the list store
  localparam int DEF_LIST_CAPACITY = 64;
  localparam int DEF_ENTRY_WIDTH   = 32;

  // fixed field widths of the request and result
  localparam int ACT_W = 3;
  localparam int POS_W = 6;
  localparam int VAL_W = 32;
  localparam int LEN_W = 7;

  // action codes
  localparam logic [ACT_W-1:0] ACT_READ   = 3'd0;
  localparam logic [ACT_W-1:0] ACT_FIND   = 3'd1;
  localparam logic [ACT_W-1:0] ACT_INSERT = 3'd2;
  localparam logic [ACT_W-1:0] ACT_REMOVE = 3'd3;
  localparam logic [ACT_W-1:0] ACT_CLEAR  = 3'd4;

  // status codes
  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_ERR = 1'b1;

  typedef struct packed {
    logic [ACT_W-1:0]        action;
    logic [POS_W-1:0]        position;
    logic signed [VAL_W-1:0] value_in;
  } request_t;

  typedef struct packed {
    logic                    status;
    logic signed [VAL_W-1:0] value_out;
    logic [POS_W-1:0]        found_position;
    logic [LEN_W-1:0]        list_length;
  } result_t;

endpackage

@@ hdl/olst_mem.sv @@
`timescale 1ns / 1ps
module olst_mem import olst_pkg::*; #(
  parameter int DEPTH = DEF_LIST_CAPACITY,
  parameter int WIDTH = DEF_ENTRY_WIDTH,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // one registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

@@ hdl/olst_seq.sv @@
`timescale 1ns / 1ps
module olst_seq import olst_pkg::*; #(
  parameter int LIST_CAPACITY = DEF_LIST_CAPACITY,
  parameter int ENTRY_WIDTH   = DEF_ENTRY_WIDTH,
  localparam int AW = (LIST_CAPACITY > 1) ? $clog2(LIST_CAPACITY) : 1
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  request_t               cmd,
  output logic                   idle,
  output logic                   done,
  input  logic                   taken,
  output result_t                res,
  output logic                   mem_we,
  output logic [AW-1:0]          mem_waddr,
  output logic [ENTRY_WIDTH-1:0] mem_wdata,
  output logic [AW-1:0]          mem_raddr,
  input  logic [ENTRY_WIDTH-1:0] mem_rdata
);

  localparam int CW    = $clog2(LIST_CAPACITY + 1);
  localparam int CMP_W = (CW > POS_W) ? CW : POS_W;
  localparam logic [CW-1:0] CAP_C = CW'(LIST_CAPACITY);
  localparam logic [CW-1:0] ONE_C = CW'(1);
  localparam logic [AW-1:0] ONE_A = AW'(1);

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_READ = 8'b0000_0010,
    S_FIND = 8'b0000_0100,
    S_UP   = 8'b0000_1000,
    S_PUT  = 8'b0001_0000,
    S_RM   = 8'b0010_0000,
    S_DN   = 8'b0100_0000,
    S_DONE = 8'b1000_0000
  } state_t;

  state_t                   state, state_next;
  logic [CW-1:0]            count, count_next;
  logic [AW-1:0]            idx, idx_next;
  logic [POS_W-1:0]         pos, pos_next;
  logic [ENTRY_WIDTH-1:0]   val, val_next;
  logic                     status, status_next;
  logic [VAL_W-1:0]         vout, vout_next;
  logic [POS_W-1:0]         fpos, fpos_next;

  logic [ENTRY_WIDTH-1:0]   cmd_val;
  logic [AW-1:0]            cmd_addr;
  logic [CMP_W-1:0]         cmd_pos_ext, count_ext;
  logic [CW-1:0]            idx_plus1;
  logic [AW-1:0]            idx_m1;

  // stored entry sign-extended or cut to the result width
  function automatic logic [VAL_W-1:0] widen(input logic [ENTRY_WIDTH-1:0] e);
    widen = VAL_W'($signed(e));
  endfunction

  // request decode helpers
  assign cmd_val     = ENTRY_WIDTH'(cmd.value_in);
  assign cmd_addr    = AW'(cmd.position);
  assign cmd_pos_ext = CMP_W'(cmd.position);
  assign count_ext   = CMP_W'(count);
  assign idx_plus1   = CW'(idx) + ONE_C;
  assign idx_m1      = idx - ONE_A;

  // sequencer and memory port control
  always_comb begin
    state_next  = state;
    count_next  = count;
    idx_next    = idx;
    pos_next    = pos;
    val_next    = val;
    status_next = status;
    vout_next   = vout;
    fpos_next   = fpos;
    mem_we      = 1'b0;
    mem_waddr   = idx;
    mem_wdata   = mem_rdata;
    mem_raddr   = idx;
    case (state)
      S_IDLE: begin
        if (start) begin
          pos_next    = cmd.position;
          val_next    = cmd_val;
          status_next = STATUS_ERR;
          vout_next   = '0;
          fpos_next   = '0;
          state_next  = S_DONE;
          case (cmd.action)
            ACT_READ: begin
              if (cmd_pos_ext < count_ext) begin
                mem_raddr  = cmd_addr;
                state_next = S_READ;
              end
            end
            ACT_FIND: begin
              if (count != '0) begin
                mem_raddr  = '0;
                idx_next   = '0;
                state_next = S_FIND;
              end
            end
            ACT_INSERT: begin
              if (count < CAP_C && cmd_pos_ext <= count_ext) begin
                if (cmd_pos_ext == count_ext) begin
                  // append needs no shift
                  mem_we      = 1'b1;
                  mem_waddr   = cmd_addr;
                  mem_wdata   = cmd_val;
                  count_next  = count + ONE_C;
                  status_next = STATUS_OK;
                end else begin
                  mem_raddr  = AW'(count - ONE_C);
                  idx_next   = AW'(count);
                  state_next = S_UP;
                end
              end
            end
            ACT_REMOVE: begin
              if (cmd_pos_ext < count_ext) begin
                mem_raddr  = cmd_addr;
                state_next = S_RM;
              end
            end
            ACT_CLEAR: begin
              count_next  = '0;
              status_next = STATUS_OK;
            end
            default: begin
            end
          endcase
        end
      end
      S_READ: begin
        vout_next   = widen(mem_rdata);
        status_next = STATUS_OK;
        state_next  = S_DONE;
      end
      // compare one entry per cycle against the search value
      S_FIND: begin
        mem_raddr = idx + ONE_A;
        if (mem_rdata == val) begin
          fpos_next   = POS_W'(idx);
          status_next = STATUS_OK;
          state_next  = S_DONE;
        end else if (idx_plus1 == count) begin
          state_next = S_DONE;
        end else begin
          idx_next = idx + ONE_A;
        end
      end
      // move entries up one place, from the top down
      S_UP: begin
        mem_we    = 1'b1;
        mem_waddr = idx;
        mem_wdata = mem_rdata;
        mem_raddr = idx - AW'(2);
        if (CMP_W'(idx_m1) == CMP_W'(pos)) begin
          state_next = S_PUT;
        end else begin
          idx_next = idx_m1;
        end
      end
      S_PUT: begin
        mem_we      = 1'b1;
        mem_waddr   = AW'(pos);
        mem_wdata   = val;
        count_next  = count + ONE_C;
        status_next = STATUS_OK;
        state_next  = S_DONE;
      end
      // capture the removed entry, then start the downward move or, for the last entry, finish
      S_RM: begin
        vout_next   = widen(mem_rdata);
        status_next = STATUS_OK;
        mem_raddr   = AW'(pos) + ONE_A;
        idx_next    = AW'(pos) + ONE_A;
        if (CW'(pos) + ONE_C == count) begin
          count_next = count - ONE_C;
          state_next = S_DONE;
        end else begin
          state_next = S_DN;
        end
      end
      // move entries down one place, from the bottom up
      S_DN: begin
        mem_we    = 1'b1;
        mem_waddr = idx_m1;
        mem_wdata = mem_rdata;
        mem_raddr = idx + ONE_A;
        if (idx_plus1 == count) begin
          count_next = count - ONE_C;
          state_next = S_DONE;
        end else begin
          idx_next = idx + ONE_A;
        end
      end
      S_DONE: begin
        if (taken) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    idx    <= idx_next;
    pos    <= pos_next;
    val    <= val_next;
    status <= status_next;
    vout   <= vout_next;
    fpos   <= fpos_next;
  end

  // status toward the top level
  assign idle               = (state == S_IDLE);
  assign done               = (state == S_DONE);
  assign res.status         = status;
  assign res.value_out      = vout;
  assign res.found_position = fpos;
  assign res.list_length    = LEN_W'(count);

endmodule

@@ hdl/ordered_array_list_unit.sv @@
`timescale 1ns / 1ps
// Ordered list of signed words with its length, one request at a time.
// Request channel: request_valid, request_stall, request (action, position,
// value_in). Result channel: result_valid, result_stall, result (status,
// value_out, found_position, list_length). A request is taken when valid is
// high and stall is low; request_stall stays high while a request is worked.
// With n the length before the request and p the position: clear, append
// and refused requests finish without walking the entries, read fetches
// the entry, find walks from position 0 to a match or the end, remove
// reads entry p and moves the entries above it down one place, and insert
// below the end moves entries n-1 down to p up one place. The entry walk
// of find, insert and remove goes one entry per cycle through the single
// read and single write port of the store; the sequencer is idle again as
// the result is loaded, and the next request is taken in the cycle after.
// Reset empties the list and drops any held result; entry contents are not
// cleared and are only ever used after being written.
// A stalled result is held in the output register; the finished request
// waits in the sequencer, and no new request is taken until it moves out.
module ordered_array_list_unit import olst_pkg::*; #(
  parameter int LIST_CAPACITY = DEF_LIST_CAPACITY,
  parameter int ENTRY_WIDTH   = DEF_ENTRY_WIDTH
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     request_valid,
  output logic     request_stall,
  input  request_t request,
  output logic     result_valid,
  input  logic     result_stall,
  output result_t  result
);

  localparam int AW = (LIST_CAPACITY > 1) ? $clog2(LIST_CAPACITY) : 1;

  logic                   seq_idle;
  logic                   seq_done;
  logic                   taken;
  result_t                seq_res;
  logic                   mem_we;
  logic [AW-1:0]          mem_waddr;
  logic [ENTRY_WIDTH-1:0] mem_wdata;
  logic [AW-1:0]          mem_raddr;
  logic [ENTRY_WIDTH-1:0] mem_rdata;

  // request side
  assign request_stall = !seq_idle;

  // result register loads when empty or being drained
  assign taken = seq_done && (!result_valid || !result_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (taken) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (taken) begin
      result <= seq_res;
    end
  end

  olst_seq #(
    .LIST_CAPACITY (LIST_CAPACITY),
    .ENTRY_WIDTH   (ENTRY_WIDTH)
  ) u_seq (
    .clk       (clk),
    .rst       (rst),
    .start     (request_valid && seq_idle),
    .cmd       (request),
    .idle      (seq_idle),
    .done      (seq_done),
    .taken     (taken),
    .res       (seq_res),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  olst_mem #(
    .DEPTH (LIST_CAPACITY),
    .WIDTH (ENTRY_WIDTH)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

endmodule
